@@ sv/tlgu_pkg.sv @@
`timescale 1ns / 1ps

package tlgu_pkg;

  localparam int MAX_SLOTS_DEF  = 2048;
  localparam int SLOT_BYTES_DEF = 32;

  localparam int SLOT_W   = 11;
  localparam int TAIL_W   = 12;
  localparam int LEN_W    = 32;
  localparam int TERM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int PLEN_W   = 31;
  localparam int CFG_W    = 12;

  localparam logic [CFG_W-1:0] TERM_SLOTS_RST = 12'd2048;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_UNBLOCK = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNBLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TO_END    = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   pad_slot;
    logic [PLEN_W-1:0]   pad_length;
    logic [TERM_W-1:0]   pad_term;
  } res_t;

endpackage

@@ sv/tlgu_if.sv @@
`timescale 1ns / 1ps

interface tlgu_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [tlgu_pkg::SLOT_W-1:0]    slot;
  logic signed [tlgu_pkg::LEN_W-1:0]  length_value;
  logic [tlgu_pkg::TAIL_W-1:0]    tail_slot;
  logic signed [tlgu_pkg::TERM_W-1:0] term_number;

  modport source (output valid, mode, slot, length_value, tail_slot, term_number,
                  input ready);
  modport sink   (input valid, mode, slot, length_value, tail_slot, term_number,
                  output ready);
endinterface

interface tlgu_out_if;
  logic                            valid;
  logic                            ready;
  logic [tlgu_pkg::STATUS_W-1:0]   status;
  logic [tlgu_pkg::SLOT_W-1:0]     pad_slot;
  logic [tlgu_pkg::PLEN_W-1:0]     pad_length;
  logic signed [tlgu_pkg::TERM_W-1:0] pad_term;

  modport source (output valid, status, pad_slot, pad_length, pad_term, input ready);
  modport sink   (input valid, status, pad_slot, pad_length, pad_term, output ready);
endinterface

@@ sv/tlgu_mem.sv @@
`timescale 1ns / 1ps

module tlgu_mem #(
  parameter int DEPTH = tlgu_pkg::MAX_SLOTS_DEF,
  parameter int WIDTH = tlgu_pkg::LEN_W,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tlgu_ctrl.sv @@
`timescale 1ns / 1ps

module tlgu_ctrl #(
  parameter int MAX_SLOTS  = tlgu_pkg::MAX_SLOTS_DEF,
  parameter int SLOT_BYTES = tlgu_pkg::SLOT_BYTES_DEF,
  parameter int ADDR_W     = $clog2(MAX_SLOTS),
  parameter int CNT_W      = (ADDR_W + 1 > tlgu_pkg::TAIL_W) ? ADDR_W + 1 : tlgu_pkg::TAIL_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [CNT_W-1:0]           t_len,
  tlgu_in_if.sink                    in_word,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_waddr,
  output logic [tlgu_pkg::LEN_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0]          mem_raddr,
  input  logic [tlgu_pkg::LEN_W-1:0] mem_rdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output tlgu_pkg::res_t             res
);

  import tlgu_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READB = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SLOTS - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_SLOTS);
  localparam logic [LEN_W-1:0]  MOST_NEG = {1'b1, {(LEN_W-1){1'b0}}};
  localparam logic [LEN_W-1:0]  MOST_POS = {1'b0, {(LEN_W-1){1'b1}}};

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  b_r, b_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  res_t              res_r, res_nxt;

  logic              accept;
  logic [CNT_W-1:0]  slot_ext;
  logic [CNT_W-1:0]  tail_ext;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  pad_end;
  logic [CNT_W-1:0]  pad_diff;
  logic [LEN_W-1:0]  pad_len;
  logic [LEN_W-1:0]  mag;

  assign in_word.ready = (state_r == ST_IDLE);
  assign accept        = in_word.valid && in_word.ready;
  assign slot_ext      = CNT_W'(in_word.slot);
  assign tail_ext      = CNT_W'(in_word.tail_slot);
  assign res_valid     = (state_r == ST_DONE);
  assign res           = res_r;

  // next slot to look at: one past the blocked slot, then one past the current one
  assign step     = (state_r == ST_READB) ? b_r + 1'b1 : cur_r + 1'b1;
  // a nonzero scan slot ends the pad at itself; otherwise the pad runs to the next slot
  assign pad_end  = (state_r == ST_SCAN && mem_rdata != '0) ? cur_r : step;
  assign pad_diff = pad_end - b_r;
  assign pad_len  = LEN_W'(pad_diff) * LEN_W'(SLOT_BYTES);
  assign mag      = (mem_rdata == MOST_NEG) ? MOST_POS : LEN_W'(-mem_rdata);

  // read address: the blocked slot at accept, the next scan slot after that
  assign mem_raddr = (state_r == ST_IDLE) ? slot_ext[ADDR_W-1:0] : step[ADDR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    b_nxt     = b_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    term_nxt  = term_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = b_r[ADDR_W-1:0];
    mem_wdata = pad_len;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
          if (in_word.mode == MODE_WRITE) begin
            if (slot_ext < MAX_CNT) begin
              mem_we    = 1'b1;
              mem_waddr = slot_ext[ADDR_W-1:0];
              mem_wdata = in_word.length_value;
            end
          end else if (slot_ext < t_len) begin
            b_nxt     = slot_ext;
            tail_nxt  = (tail_ext > t_len) ? t_len : tail_ext;
            term_nxt  = in_word.term_number;
            state_nxt = ST_READB;
          end
        end
      end
      ST_READB, ST_SCAN: begin
        res_nxt = '0;
        if (state_r == ST_READB && mem_rdata[LEN_W-1]) begin
          mem_we     = 1'b1;
          mem_wdata  = mag;
          res_nxt    = '{STAT_UNBLOCKED, b_r[SLOT_W-1:0], mag[PLEN_W-1:0], term_r};
          state_nxt  = ST_DONE;
        end else if (mem_rdata != '0) begin
          // nonzero blocked slot: no action; nonzero scan slot: pad up to it
          if (state_r == ST_SCAN) begin
            mem_we  = 1'b1;
            res_nxt = '{STAT_UNBLOCKED, b_r[SLOT_W-1:0], pad_len[PLEN_W-1:0], term_r};
          end
          state_nxt = ST_DONE;
        end else if (step < tail_r) begin
          cur_nxt   = step;
          state_nxt = ST_SCAN;
        end else begin
          if (step == t_len) begin
            mem_we  = 1'b1;
            res_nxt = '{STAT_TO_END, b_r[SLOT_W-1:0], pad_len[PLEN_W-1:0], term_r};
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    tail_r <= tail_nxt;
    cur_r  <= cur_nxt;
    term_r <= term_nxt;
    res_r  <= res_nxt;
  end

  // every write after the clear pass closes its word, so no later read can race it
  a_write_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |=> (state_r == ST_DONE))
    else $error("store write outside the final cycle of a word");

  a_scan_below_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cur_r < tail_r && b_r < cur_r))
    else $error("scan slot outside blocked..tail range");

  a_tail_in_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READB || state_r == ST_SCAN) |-> (tail_r <= t_len && b_r < t_len))
    else $error("blocked or tail slot beyond term length");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.status == STAT_NONE) |->
      (res_r.pad_length == '0 && res_r.pad_slot == '0 && res_r.pad_term == '0))
    else $error("no-action result carries pad fields");

endmodule

@@ sv/term_log_gap_unblocker_unit.sv @@
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+------------------------------------------
// in_word   | in  | valid/ready          | mode, slot, length_value, tail_slot, term_number
// out_word  | out | valid/ready          | status, pad_slot, pad_length, pad_term
// cfg       | in  | cfg_we, no stall     | cfg_wdata = term_slots
//
// After reset the length store is swept to zero, one slot a cycle, with in_word.ready
// held low. A write word, or an unblock word whose slot lies at or beyond the term,
// goes straight to its result. Any other unblock word reads the blocked slot, then
// scans the slots after it, up to the tail slot: one store read per slot
// through the single read port. A word's result sits in the output register, so the
// next word is taken while out_word is stalled; the controller waits only when that
// register is still full at the end of the next word.
`timescale 1ns / 1ps

module term_log_gap_unblocker_unit #(
  parameter int MAX_SLOTS  = tlgu_pkg::MAX_SLOTS_DEF,
  parameter int SLOT_BYTES = tlgu_pkg::SLOT_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tlgu_in_if.sink                    in_word,
  tlgu_out_if.source                 out_word,
  input  logic                       cfg_we,
  input  logic [tlgu_pkg::CFG_W-1:0] cfg_wdata
);

  import tlgu_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = (ADDR_W + 1 > TAIL_W) ? ADDR_W + 1 : TAIL_W;

  localparam logic [CNT_W-1:0] MIN_TERM = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_TERM = CNT_W'(MAX_SLOTS);

  logic [CFG_W-1:0]  term_slots_r;
  logic [CNT_W-1:0]  ts_ext;
  logic [CNT_W-1:0]  t_len;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [LEN_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [LEN_W-1:0]  mem_rdata;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_slots_r <= TERM_SLOTS_RST;
    end else if (cfg_we) begin
      term_slots_r <= cfg_wdata;
    end
  end

  assign ts_ext = CNT_W'(term_slots_r);
  assign t_len  = (ts_ext < MIN_TERM) ? MIN_TERM : (ts_ext > MAX_TERM) ? MAX_TERM : ts_ext;

  tlgu_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (LEN_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tlgu_ctrl #(
    .MAX_SLOTS  (MAX_SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .t_len     (t_len),
    .in_word   (in_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.status     = out_res_r.status;
  assign out_word.pad_slot   = out_res_r.pad_slot;
  assign out_word.pad_length = out_res_r.pad_length;
  assign out_word.pad_term   = out_res_r.pad_term;

endmodule
